// File: sv/plc_pkg.sv
`default_nettype none

package plc_pkg;

  // table size and derived widths
  localparam int MAX_POINTS  = 16;
  localparam int IDX_W       = $clog2(MAX_POINTS);
  localparam int CNT_W       = $clog2(MAX_POINTS + 1);
  localparam int COUNT_OUT_W = 5;

  // iterative divider: one quotient bit per step
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // command codes
  localparam logic CMD_APPEND   = 1'b0;
  localparam logic CMD_EVALUATE = 1'b1;

  // status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_DROPPED = 1'b1;

  typedef struct packed {
    logic              command;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0]     curve_value;
    logic [30:0]            max_y;
    logic                   status;
    logic [COUNT_OUT_W-1:0] point_count;
  } out_item_t;

endpackage

`default_nettype wire

// File: sv/plc_if.sv
`default_nettype none

interface plc_in_if
  import plc_pkg::*;
;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface plc_out_if
  import plc_pkg::*;
;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/plc_div.sv
`default_nettype none

// restoring divider, 64 by 32 bits, quotient known to fit in 32 bits
module plc_div
  import plc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic [31:0]          rem_r, rem_nxt;
  logic [31:0]          lo_r, lo_nxt;
  logic [31:0]          den_r;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [32:0]          trial;
  logic [32:0]          diff;
  logic                 fits;

  assign trial = {rem_r, lo_r[31]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = trial >= {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = dividend[63:32];
      lo_nxt   = dividend[31:0];
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[31:0] : trial[31:0];
      lo_nxt  = {lo_r[30:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    if (start) begin
      den_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = lo_r;

endmodule

`default_nettype wire

// File: sv/piecewise_linear_curve.sv
// piecewise linear curve over a table of signed Q16.16 breakpoints
//
// in_ch carries one beat per command: append (x, y) to the table, or
// evaluate the curve at x. out_ch returns exactly one beat per command
// with the curve value (0 on append), the running maximum of stored y
// (never below 0), a dropped flag for an append to a full table and the
// number of stored points after the command.
//
// an append or an evaluate on an empty table answers in the next cycle. an
// evaluate reads point 0 and the last point (a query clamped at either end
// answers there), then scans the table one entry per cycle through the
// single read port of the point memory (segment k, 1 to count - 1),
// multiplies and runs the 32-step shift-subtract divider, which flags done
// from a register. the next beat is taken in the cycle the result is taken,
// so only one command is ever in flight.
//
// reset empties the table and clears the maximum; no clearing pass.
// the result sits in an output register until taken; while it waits,
// in_ch stays not ready unless out_ch takes it in the same cycle.
`default_nettype none

module piecewise_linear_curve
  import plc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  plc_in_if.sink     in_ch,
  plc_out_if.source  out_ch
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FIRST = 6'b000010,
    S_LAST  = 6'b000100,
    S_SCAN  = 6'b001000,
    S_MUL   = 6'b010000,
    S_DIV   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // table bookkeeping
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic signed [31:0] largest_r, largest_nxt;

  // point memory, one write and one registered read port
  logic signed [31:0] point_x_mem [MAX_POINTS];
  logic signed [31:0] point_y_mem [MAX_POINTS];
  logic [IDX_W-1:0]   rd_idx;
  logic signed [31:0] rd_x_r, rd_y_r;
  logic               wr_en;

  // evaluation working registers
  logic signed [31:0] qx_r, qx_nxt;
  logic signed [31:0] px_r, px_nxt;
  logic signed [31:0] py_r, py_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [31:0]        mag_r, mag_nxt;
  logic [31:0]        num_r, num_nxt;
  logic [31:0]        den_r, den_nxt;
  logic               neg_r, neg_nxt;
  logic signed [32:0] dy;

  // output register
  out_item_t out_r, out_nxt;
  logic      out_valid_r, out_valid_nxt;

  // divider hookup
  logic        div_start;
  logic        div_done;
  logic [31:0] div_quo;
  logic [63:0] product;

  logic accept;

  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  // the only multiplier; its product goes straight into the divider registers
  assign product = mag_r * num_r;

  assign dy = {rd_y_r[31], rd_y_r} - {py_r[31], py_r};

  function automatic out_item_t make_result(logic signed [31:0] value,
                                            logic signed [31:0] largest,
                                            logic status,
                                            logic [CNT_W-1:0] count);
    out_item_t r;
    r.curve_value = value;
    r.max_y       = largest[30:0];
    r.status      = status;
    r.point_count = COUNT_OUT_W'(count);
    return r;
  endfunction

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    largest_nxt   = largest_r;
    qx_nxt        = qx_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    idx_nxt       = idx_r;
    mag_nxt       = mag_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    neg_nxt       = neg_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    rd_idx        = '0;
    wr_en         = 1'b0;
    div_start     = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_ch.data.command == CMD_APPEND) begin
            if (count_r < CNT_W'(MAX_POINTS)) begin
              wr_en     = 1'b1;
              count_nxt = count_r + 1'b1;
              if (in_ch.data.y_value > largest_r) begin
                largest_nxt = in_ch.data.y_value;
              end
              out_nxt = make_result('0, largest_nxt, STATUS_OK, count_nxt);
            end else begin
              // full table: drop the point, nothing changes
              out_nxt = make_result('0, largest_r, STATUS_DROPPED, count_r);
            end
            out_valid_nxt = 1'b1;
          end else begin
            qx_nxt = in_ch.data.x_value;
            if (count_r == '0) begin
              out_nxt       = make_result('0, largest_r, STATUS_OK, count_r);
              out_valid_nxt = 1'b1;
            end else begin
              rd_idx    = '0;
              state_nxt = S_FIRST;
            end
          end
        end
      end

      S_FIRST: begin
        // at or below the first x: clamp to the first y
        if (qx_r <= rd_x_r) begin
          out_nxt       = make_result(rd_y_r, largest_r, STATUS_OK, count_r);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          px_nxt    = rd_x_r;
          py_nxt    = rd_y_r;
          rd_idx    = IDX_W'(count_r - 1'b1);
          state_nxt = S_LAST;
        end
      end

      S_LAST: begin
        // at or above the last x: clamp to the last y
        if (qx_r >= rd_x_r) begin
          out_nxt       = make_result(rd_y_r, largest_r, STATUS_OK, count_r);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          rd_idx    = IDX_W'(1);
          idx_nxt   = IDX_W'(1);
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        // rd_x_r/rd_y_r hold entry idx_r; the next entry is read meanwhile if the scan goes on
        if (qx_r < rd_x_r) begin
          num_nxt   = 32'(qx_r - px_r);
          den_nxt   = 32'(rd_x_r - px_r);
          neg_nxt   = dy[32];
          mag_nxt   = dy[32] ? 32'(-dy) : 32'(dy);
          state_nxt = S_MUL;
        end else begin
          px_nxt    = rd_x_r;
          py_nxt    = rd_y_r;
          idx_nxt   = idx_r + 1'b1;
          rd_idx    = idx_r + 1'b1;
        end
      end

      S_MUL: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end

      S_DIV: begin
        if (div_done) begin
          out_nxt = make_result(neg_r ? py_r - $signed(div_quo) : py_r + $signed(div_quo),
                                largest_r, STATUS_OK, count_r);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      largest_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      largest_r   <= largest_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    qx_r  <= qx_nxt;
    px_r  <= px_nxt;
    py_r  <= py_nxt;
    idx_r <= idx_nxt;
    mag_r <= mag_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
    out_r <= out_nxt;
  end

  // point memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      point_x_mem[IDX_W'(count_r)] <= in_ch.data.x_value;
      point_y_mem[IDX_W'(count_r)] <= in_ch.data.y_value;
    end
    rd_x_r <= point_x_mem[rd_idx];
    rd_y_r <= point_y_mem[rd_idx];
  end

  plc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (product),
    .divisor  (den_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  // divider finishes only while the sequencer waits for it
  assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider done outside division state");

  // point count never passes the table size
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_POINTS))
    else $error("point count beyond table size");

  // an append to a full table leaves count and maximum alone
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.data.command == CMD_APPEND && count_r == CNT_W'(MAX_POINTS))
      |=> $stable(count_r) && $stable(largest_r))
    else $error("dropped append changed the table");

  // a dropped flag only goes out with a full table
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == STATUS_DROPPED) |-> count_r == CNT_W'(MAX_POINTS))
    else $error("dropped flag with table not full");

endmodule

`default_nettype wire

// File: test/tb_top.sv
`default_nettype none

module tb_top
  import plc_pkg::*;
;

  // run limit in clock cycles, far beyond the slowest legal run
  localparam int TIMEOUT_CYCLES = 500_000;
  // quiet cycles after the last awaited beat, above the worst evaluate latency
  localparam int DRAIN_CYCLES   = 80;

  localparam logic signed [31:0] X_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] X_MAX = 32'sh7fff_ffff;

  logic clk;
  logic rst_n;

  plc_in_if  in_ch ();
  plc_out_if out_ch ();

  piecewise_linear_curve DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // breakpoint table as the block should hold it
  logic signed [31:0] table_x [MAX_POINTS];
  logic signed [31:0] table_y [MAX_POINTS];
  int                 table_count;
  logic signed [31:0] running_max;

  // result beats owed by the block, oldest first
  out_item_t awaited_beats [$];

  int error_count;
  int send_gap_pct;
  int recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_CYCLES * 12);
    $display("FAIL");
    $finish;
  end

  // receiver side: ready is redrawn every cycle, stall rate set per phase
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // curve value at qx over the current table, truncating division
  function automatic logic signed [31:0] curve_at(logic signed [31:0] qx);
    longint      base_y;
    longint      rise;
    logic [63:0] run;
    logic [63:0] span;
    logic [63:0] mag;
    logic [63:0] step;
    if (table_count == 0) return '0;
    if (qx <= table_x[0]) return table_y[0];
    if (qx >= table_x[table_count-1]) return table_y[table_count-1];
    // first segment whose upper x lies above the query
    for (int i = 1; i < table_count; i++) begin
      if (qx < table_x[i]) begin
        base_y = table_y[i-1];
        rise   = longint'(table_y[i]) - base_y;
        run    = 64'(longint'(qx) - longint'(table_x[i-1]));
        span   = 64'(longint'(table_x[i]) - longint'(table_x[i-1]));
        if (span == 0) return 32'(base_y);
        mag  = (rise < 0) ? 64'(-rise) : 64'(rise);
        // product stays below 2**64, so unsigned 64-bit math is exact
        step = (mag * run) / span;
        if (rise < 0) return 32'(base_y - longint'(step));
        return 32'(base_y + longint'(step));
      end
    end
    return '0;
  endfunction

  // applies one accepted command to the table and returns the beat it owes
  function automatic out_item_t apply_curve_command(in_item_t item);
    out_item_t          res;
    logic signed [31:0] px;
    logic signed [31:0] py;
    px  = item.x_value;
    py  = item.y_value;
    res = '0;
    res.status = STATUS_OK;
    if (item.command == CMD_APPEND) begin
      if (table_count < MAX_POINTS) begin
        table_x[table_count] = px;
        table_y[table_count] = py;
        table_count++;
        // maximum starts at 0, so negative y never shows up here
        if (py > running_max) running_max = py;
      end else begin
        res.status = STATUS_DROPPED;
      end
    end else begin
      res.curve_value = curve_at(px);
    end
    res.max_y       = running_max[30:0];
    res.point_count = COUNT_OUT_W'(table_count);
    return res;
  endfunction

  // query x aimed at the interesting spots of the current table
  function automatic logic signed [31:0] pick_query_x();
    int          k;
    int          idx;
    longint      lo;
    longint      hi;
    logic [63:0] r64;
    k = $urandom_range(9);
    if (table_count == 0 || k == 0) return $urandom;
    if (k == 1) return $urandom_range(1) ? X_MAX : X_MIN;
    idx = $urandom_range(table_count - 1);
    if (k == 2) return table_x[idx];
    if (k == 3) return table_x[idx] + ($urandom_range(1) ? 1 : -1);
    if (table_count < 2) return $urandom;
    // somewhere between two neighboring breakpoints, either order
    idx = $urandom_range(table_count - 2);
    lo  = table_x[idx];
    hi  = table_x[idx+1];
    if (lo > hi) begin
      lo = table_x[idx+1];
      hi = table_x[idx];
    end
    r64 = {$urandom, $urandom};
    return 32'(lo + longint'(r64 % 64'(hi - lo + 1)));
  endfunction

  function automatic logic signed [31:0] small_value();
    return int'($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
  endfunction

  // one input beat; entered and left just after a falling edge
  task automatic send_cmd(input logic cmd, input logic signed [31:0] x,
                          input logic signed [31:0] y);
    in_item_t item;
    item.command = cmd;
    item.x_value = x;
    item.y_value = y;
    while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= item;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    awaited_beats.insert(awaited_beats.size(), apply_curve_command(item));
    @(negedge clk);
  endtask

  task automatic send_random_append();
    logic signed [31:0] x;
    logic signed [31:0] y;
    case ($urandom_range(2))
      0: x = $urandom;
      1: x = small_value();
      default: begin
        // mostly rising tables give long chains of real segments
        if (table_count > 0) x = table_x[table_count-1] + int'($urandom_range(32'h0004_0000));
        else x = small_value();
      end
    endcase
    y = ($urandom_range(3) == 0) ? small_value() : $urandom;
    send_cmd(CMD_APPEND, x, y);
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, field, want, got);
      error_count++;
    end
  endtask

  // result side: every accepted beat is matched against the oldest owed one
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (awaited_beats.size() == 0) begin
        $display("%0t: unexpected beat, expected none got %h", $time, out_ch.data);
        error_count++;
      end else begin
        want = awaited_beats.pop_front();
        check_field("curve_value", want.curve_value, out_ch.data.curve_value);
        check_field("max_y", 32'(want.max_y), 32'(out_ch.data.max_y));
        check_field("status", 32'(want.status), 32'(out_ch.data.status));
        check_field("point_count", 32'(want.point_count), 32'(out_ch.data.point_count));
      end
    end
  end

  // evaluate with nothing stored gives 0
  task automatic test_empty_table();
    send_cmd(CMD_EVALUATE, X_MIN, X_MAX);
    send_cmd(CMD_EVALUATE, X_MAX, X_MIN);
    send_cmd(CMD_EVALUATE, 32'sd0, 32'sd0);
  endtask

  // clamping at both ends, widest slopes both ways, unsorted and repeated x
  task automatic test_segments();
    // negative y leaves the maximum at its floor of 0
    send_cmd(CMD_APPEND, X_MIN, X_MIN);
    // single point: every query returns its y
    send_cmd(CMD_EVALUATE, 32'sd5, 32'sd0);
    send_cmd(CMD_EVALUATE, X_MIN, 32'sd0);
    send_cmd(CMD_APPEND, 32'sd0, X_MAX);
    send_cmd(CMD_APPEND, X_MAX, X_MIN);
    send_cmd(CMD_EVALUATE, X_MIN, 32'sd0);
    send_cmd(CMD_EVALUATE, X_MAX, 32'sd0);
    send_cmd(CMD_EVALUATE, -32'sd1, 32'sd0);
    send_cmd(CMD_EVALUATE, 32'sd1, 32'sd0);
    send_cmd(CMD_EVALUATE, 32'sd0, 32'sd0);
    send_cmd(CMD_EVALUATE, X_MIN + 1, 32'sd0);
    send_cmd(CMD_EVALUATE, X_MAX - 1, 32'sd0);
    send_cmd(CMD_EVALUATE, 32'sh4000_0000, 32'sd0);
    // last point out of order: the high end now clamps at x = -100
    send_cmd(CMD_APPEND, -32'sd100, 32'sd5);
    send_cmd(CMD_EVALUATE, -32'sd100, 32'sd0);
    send_cmd(CMD_EVALUATE, -32'sd101, 32'sd0);
    send_cmd(CMD_EVALUATE, X_MAX, 32'sd0);
    // same x twice in a row
    send_cmd(CMD_APPEND, -32'sd100, -32'sd7);
    send_cmd(CMD_EVALUATE, -32'sd100, 32'sd0);
    send_cmd(CMD_EVALUATE, -32'sd150, 32'sd0);
  endtask

  // appends to a full table are dropped and leave everything as it was
  task automatic test_full_table();
    while (table_count < MAX_POINTS) send_random_append();
    send_cmd(CMD_APPEND, X_MAX, X_MAX);
    send_cmd(CMD_APPEND, X_MIN, X_MIN);
    send_cmd(CMD_EVALUATE, X_MIN, X_MAX);
    send_cmd(CMD_EVALUATE, X_MAX, X_MIN);
  endtask

  // mostly evaluates, with appends until the table fills and a few beyond
  task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                     input int beats);
    send_gap_pct   = sender_pct;
    recv_stall_pct = receiver_pct;
    repeat (beats) begin
      if (table_count < MAX_POINTS ? ($urandom_range(9) == 0) : ($urandom_range(19) == 0))
        send_random_append();
      else
        send_cmd(CMD_EVALUATE, pick_query_x(), $urandom);
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.data     = '0;
    out_ch.ready   = 1'b0;
    table_count    = 0;
    running_max    = '0;
    error_count    = 0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_segments();
    test_random_traffic(0, 0, 205);
    test_full_table();
    test_random_traffic(78, 0, 205);
    test_random_traffic(0, 78, 205);
    test_random_traffic(14, 14, 205);
    in_ch.valid <= 1'b0;

    // drain, then leave room for any stray beat to show up
    while (awaited_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
